@@ hw/rtl/abat_pkg.sv @@
`default_nettype none

package abat_pkg;

   localparam int CHANNELS_DEF = 13;
   localparam int CHAN_W       = 4;
   localparam int SAMPLE_BITS  = 10;
   localparam int LEARN_LOG2   = 5;
   localparam int SUM_W        = SAMPLE_BITS + LEARN_LOG2;
   localparam int MARGIN_W     = 8;
   localparam int HIST_W       = 8;
   localparam int RISE_W       = 8;
   localparam int HOLD_W       = 16;
   localparam int PTS_W        = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};

   typedef enum logic [2:0] {
      MODE_LEARN  = 3'd0,
      MODE_CHECK  = 3'd1,
      MODE_RESYNC = 3'd2,
      MODE_TICK   = 3'd3,
      MODE_MARGIN = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATIC_LOW   = 3'd0,
      CSR_STATIC_HIGH  = 3'd1,
      CSR_ALARM_POINTS = 3'd2,
      CSR_RISE_POINTS  = 3'd3,
      CSR_HOLD_TICKS   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] static_low;
      logic [SAMPLE_BITS-1:0] static_high;
      logic [PTS_W-1:0]       alarm_points;
      logic [RISE_W-1:0]      rise_points;
      logic [HOLD_W-1:0]      hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] base;
      logic [SAMPLE_BITS-1:0] limit;
      logic [SUM_W-1:0]       sum;
      logic [LEARN_LOG2-1:0]  lcount;
      logic                   pair;
      logic [HIST_W-1:0]      hist;
      logic [RISE_W-1:0]      rise;
      logic [HOLD_W-1:0]      hold;
      logic [1:0]             flags;
      logic [MARGIN_W-1:0]    margin;
   } entry_type;

   localparam logic [HIST_W-1:0] MASK_TABLE [5] = '{8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF};

   function automatic logic [HIST_W-1:0] point_mask(input logic [PTS_W-1:0] pts);
      logic [HIST_W-1:0] m;
      begin
         if (pts <= PTS_W'(4)) begin
            m = MASK_TABLE[0];
         end else if (pts >= PTS_W'(8)) begin
            m = MASK_TABLE[4];
         end else begin
            m = MASK_TABLE[3'(pts - PTS_W'(4))];
         end
         return m;
      end
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] limit_of(input logic [SAMPLE_BITS-1:0] b,
                                                      input logic [MARGIN_W-1:0] m);
      logic [SAMPLE_BITS-1:0] r;
      begin
         if ((SMAX - b) > SAMPLE_BITS'(m)) begin
            r = b + SAMPLE_BITS'(m);
         end else begin
            r = SMAX;
         end
         return r;
      end
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/abat_if.sv @@
`default_nettype none

interface abat_req_if;
   import abat_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [2:0]             mode;
   logic [CHAN_W-1:0]      channel;
   logic [SAMPLE_BITS-1:0] value;
   modport source (output valid, output mode, output channel, output value, input ready);
   modport sink (input valid, input mode, input channel, input value, output ready);
endinterface

interface abat_rsp_if;
   import abat_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   ext_alarm;
   logic                   static_alarm;
   logic [SAMPLE_BITS-1:0] baseline;
   logic [SAMPLE_BITS-1:0] upper_limit;
   logic                   over_now;
   logic                   learn_done;
   modport source (output valid, output ext_alarm, output static_alarm, output baseline,
                   output upper_limit, output over_now, output learn_done, input ready);
   modport sink (input valid, input ext_alarm, input static_alarm, input baseline,
                 input upper_limit, input over_now, input learn_done, output ready);
endinterface

interface abat_csr_if;
   import abat_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/abat_update.sv @@
`default_nettype none

module abat_update (
   input  abat_pkg::entry_type              cur,
   input  logic [2:0]                       mode,
   input  logic [abat_pkg::SAMPLE_BITS-1:0] value,
   input  abat_pkg::cfg_type                cfg,
   input  logic                             is_last,
   output abat_pkg::entry_type              nxt,
   output logic                             over_now,
   output logic                             learn_done
);
   import abat_pkg::*;

   logic [SUM_W-1:0]  sum_v;
   logic [SUM_W-1:0]  avg_v;
   logic [SUM_W-1:0]  base_w;
   logic [SUM_W-1:0]  diff_v;
   logic [RISE_W-1:0] rise_v;
   logic [HIST_W-1:0] hist_v;
   logic [HIST_W-1:0] mask_v;
   logic              static_bad;

   assign mask_v = point_mask(cfg.alarm_points);

   always_comb begin
      nxt        = cur;
      over_now   = 1'b0;
      learn_done = 1'b0;
      sum_v      = '0;
      avg_v      = '0;
      base_w     = SUM_W'(cur.base);
      diff_v     = '0;
      rise_v     = cur.rise;
      hist_v     = cur.hist;
      case (mode)
         MODE_LEARN: begin
            sum_v = (cur.lcount == '0) ? '0 : cur.sum;
            sum_v = sum_v + SUM_W'(value);
            if (&cur.lcount) begin
               nxt.base   = sum_v[SUM_W-1 -: SAMPLE_BITS];
               nxt.limit  = limit_of(nxt.base, cur.margin);
               nxt.sum    = '0;
               nxt.pair   = 1'b0;
               nxt.lcount = '0;
               learn_done = 1'b1;
               nxt.flags[1] = static_bad;
            end else begin
               nxt.lcount = cur.lcount + LEARN_LOG2'(1);
               nxt.sum    = sum_v;
            end
         end
         MODE_CHECK: begin
            hist_v = {cur.hist[HIST_W-2:0], 1'b0};
            if (value <= cur.limit) begin
               sum_v   = cur.sum + SUM_W'(value);
               nxt.sum = sum_v;
               if (cur.pair) begin
                  avg_v = sum_v >> 1;
                  if (base_w > avg_v + SUM_W'(1)) begin
                     diff_v    = base_w - avg_v;
                     nxt.base  = cur.base - SAMPLE_BITS'(diff_v >> 1);
                     nxt.limit = limit_of(nxt.base, cur.margin);
                     nxt.rise  = '0;
                  end else if (avg_v > base_w + SUM_W'(1)) begin
                     rise_v   = (cur.rise != {RISE_W{1'b1}}) ? cur.rise + RISE_W'(1) : cur.rise;
                     nxt.rise = rise_v;
                     if (rise_v >= cfg.rise_points) begin
                        if (cur.base != SMAX) begin
                           nxt.base = cur.base + SAMPLE_BITS'(1);
                           if (cur.limit != SMAX) begin
                              nxt.limit = cur.limit + SAMPLE_BITS'(1);
                           end
                        end
                        nxt.rise = '0;
                     end
                  end
                  nxt.sum  = '0;
                  nxt.pair = 1'b0;
               end else begin
                  nxt.pair = 1'b1;
               end
            end else begin
               hist_v[0] = 1'b1;
               over_now  = 1'b1;
            end
            nxt.hist = hist_v;
            if ((hist_v & mask_v) == mask_v) begin
               nxt.flags[0] = 1'b1;
               nxt.hold     = cfg.hold_ticks;
               nxt.base     = value;
               nxt.limit    = limit_of(value, cur.margin);
               nxt.sum      = '0;
               nxt.pair     = 1'b0;
               nxt.rise     = '0;
            end else if ((hist_v & mask_v) == '0 && cur.hold == '0) begin
               nxt.flags[0] = 1'b0;
            end
            nxt.flags[1] = static_bad;
         end
         MODE_RESYNC: begin
            nxt.base     = value;
            nxt.limit    = limit_of(value, cur.margin);
            nxt.flags[1] = static_bad;
         end
         MODE_TICK: begin
            if (cur.hold != '0) begin
               nxt.hold = cur.hold - HOLD_W'(1);
            end
         end
         MODE_MARGIN: begin
            nxt.margin = value[MARGIN_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // The static check looks at the baseline the step has just produced.
   logic [SAMPLE_BITS-1:0] check_base;

   always_comb begin
      case (mode)
         MODE_LEARN:  check_base = sum_v[SUM_W-1 -: SAMPLE_BITS];
         MODE_RESYNC: check_base = value;
         MODE_CHECK: begin
            if ((hist_v & mask_v) == mask_v) begin
               check_base = value;
            end else if (value <= cur.limit && cur.pair && base_w > avg_v + SUM_W'(1)) begin
               check_base = cur.base - SAMPLE_BITS'(diff_v >> 1);
            end else if (value <= cur.limit && cur.pair && avg_v > base_w + SUM_W'(1)
                         && rise_v >= cfg.rise_points && cur.base != SMAX) begin
               check_base = cur.base + SAMPLE_BITS'(1);
            end else begin
               check_base = cur.base;
            end
         end
         default: check_base = cur.base;
      endcase
   end

   assign static_bad = !is_last &&
                       (check_base < cfg.static_low || check_base > cfg.static_high);

endmodule

`default_nettype wire

@@ hw/rtl/adaptive_baseline_alarm_tracker.sv @@
`default_nettype none

// Tracks the baseline and alarm state of a bank of tension-sensor channels. Each request word
// names a channel and a mode (learn, check, resync, tick, load margin) and yields exactly one
// response word with that channel's flags, baseline and upper limit after the step. All channel
// state sits in one synchronous memory entry per channel; a request reads its entry while idle,
// then updates it, writes it back and loads the response register in the run state, waiting
// while the response is held. No new request is taken meanwhile. Requests for a channel beyond
// the bank change nothing and return an all-zero word. Configuration registers must be written
// on the csr port only while no request is in flight (not enforced); they apply to the next request.
module adaptive_baseline_alarm_tracker #(
   parameter int CHANNELS = abat_pkg::CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   abat_req_if.sink   req_chan,
   abat_rsp_if.source rsp_chan,
   abat_csr_if.sink   csr_chan
);
   import abat_pkg::*;

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type               state_ff;
   logic [2:0]              mode_ff;
   logic [AW-1:0]           chan_ff;
   logic                    chan_ok_ff;
   logic [SAMPLE_BITS-1:0]  value_ff;
   cfg_type                 cfg_ff;

   entry_type               mem_ff [CHANNELS];
   logic [CHANNELS-1:0]     vld_ff;
   entry_type               rd_ff;
   logic                    rd_vld_ff;

   logic                    rsp_valid_ff;
   logic                    ext_alarm_ff;
   logic                    static_alarm_ff;
   logic [SAMPLE_BITS-1:0]  baseline_ff;
   logic [SAMPLE_BITS-1:0]  upper_limit_ff;
   logic                    over_now_ff;
   logic                    learn_done_ff;

   logic                    req_ok;
   logic                    req_fire;
   logic [AW-1:0]           rd_addr;
   logic                    out_free;
   logic                    wr_en;
   entry_type               cur;
   entry_type               nxt;
   logic                    over_now;
   logic                    learn_done;
   logic                    is_last;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_ok         = (int'(req_chan.channel) < CHANNELS);
   assign rd_addr        = (state_ff == S_IDLE) ? (req_ok ? AW'(req_chan.channel) : '0) : chan_ff;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign wr_en          = (state_ff == S_RUN) && out_free && chan_ok_ff;
   assign cur            = rd_vld_ff ? rd_ff : '0;
   assign is_last        = (int'(chan_ff) == CHANNELS - 1);

   abat_update u_update (
      .cur        (cur),
      .mode       (mode_ff),
      .value      (value_ff),
      .cfg        (cfg_ff),
      .is_last    (is_last),
      .nxt        (nxt),
      .over_now   (over_now),
      .learn_done (learn_done)
   );

   always_ff @(posedge clock) begin
      rd_ff     <= mem_ff[rd_addr];
      rd_vld_ff <= vld_ff[rd_addr];
      if (wr_en) begin
         mem_ff[chan_ff] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[chan_ff] <= 1'b1;
      end
   end

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.static_low   <= '0;
         cfg_ff.static_high  <= SMAX;
         cfg_ff.alarm_points <= PTS_W'(6);
         cfg_ff.rise_points  <= RISE_W'(8);
         cfg_ff.hold_ticks   <= HOLD_W'(100);
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_STATIC_LOW:   cfg_ff.static_low   <= csr_chan.data[SAMPLE_BITS-1:0];
            CSR_STATIC_HIGH:  cfg_ff.static_high  <= csr_chan.data[SAMPLE_BITS-1:0];
            CSR_ALARM_POINTS: cfg_ff.alarm_points <= csr_chan.data[PTS_W-1:0];
            CSR_RISE_POINTS:  cfg_ff.rise_points  <= csr_chan.data[RISE_W-1:0];
            CSR_HOLD_TICKS:   cfg_ff.hold_ticks   <= csr_chan.data[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready && state_ff != S_RUN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  mode_ff    <= req_chan.mode;
                  chan_ff    <= rd_addr;
                  chan_ok_ff <= req_ok;
                  value_ff   <= req_chan.value;
                  state_ff   <= S_RUN;
               end
            end
            S_RUN: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  ext_alarm_ff    <= chan_ok_ff && nxt.flags[0];
                  static_alarm_ff <= chan_ok_ff && nxt.flags[1];
                  baseline_ff     <= chan_ok_ff ? nxt.base : '0;
                  upper_limit_ff  <= chan_ok_ff ? nxt.limit : '0;
                  over_now_ff     <= chan_ok_ff && over_now;
                  learn_done_ff   <= chan_ok_ff && learn_done;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ext_alarm    = ext_alarm_ff;
   assign rsp_chan.static_alarm = static_alarm_ff;
   assign rsp_chan.baseline     = baseline_ff;
   assign rsp_chan.upper_limit  = upper_limit_ff;
   assign rsp_chan.over_now     = over_now_ff;
   assign rsp_chan.learn_done   = learn_done_ff;

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_RUN)
      else $error("accepted request did not start an update");

   a_write_in_run: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_RUN && chan_ok_ff))
      else $error("memory written outside an update of a valid channel");

   a_write_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("entry written back without a response");

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> vld_ff == '0)
      else $error("entry valid bits not cleared by reset");

endmodule

`default_nettype wire
